// ===== rtl/qpd_pkg.sv =====
package qpd_pkg;

  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam int unsigned MaxBytes = 3;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // pending escape codes
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  typedef logic [MaxBytes-1:0][7:0] qpd_bytes_t;

  // one queue entry: up to three decoded bytes from a single request
  typedef struct packed {
    qpd_bytes_t bytes;
    logic [1:0] last_idx;
  } qpd_entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/qpd_front.sv =====
module qpd_front
  import qpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       dot_stuffing_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       msg_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output qpd_entry_t q_entry_o
);

  logic [1:0] pend_q, pend_d;
  logic [7:0] lead_q, lead_d;
  logic       line_q, line_d;
  qpd_bytes_t buf_b;
  logic [1:0] n;
  logic       accept;
  logic       is_crlf;

  function automatic qpd_bytes_t put_byte(input qpd_bytes_t b, input logic [1:0] idx,
                                          input logic [7:0] v);
    qpd_bytes_t r;
    r = b;
    case (idx)
      2'd0: r[0] = v;
      2'd1: r[1] = v;
      2'd2: r[2] = v;
      default: ;
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_crlf    = (in_byte_i == CH_CR) || (in_byte_i == CH_LF);

  always_comb begin
    buf_b  = '0;
    n      = 2'd0;
    pend_d = pend_q;
    lead_d = lead_q;
    line_d = line_q;
    if (pend_q != PEND_NONE) begin
      if (pend_q == PEND_TWO && is_crlf) begin
        // soft break; CR keeps the escape open
        line_d = 1'b1;
        if (in_byte_i == CH_LF) begin
          pend_d = PEND_NONE;
        end
      end else if (!is_hex(in_byte_i)) begin
        if (is_crlf) begin
          line_d = 1'b1;
        end else begin
          buf_b = put_byte(buf_b, n, CH_EQ);
          n     = n + 2'd1;
          if (pend_q == PEND_ONE) begin
            buf_b = put_byte(buf_b, n, lead_q);
            n     = n + 2'd1;
          end
          buf_b = put_byte(buf_b, n, in_byte_i);
          n     = n + 2'd1;
        end
        pend_d = PEND_NONE;
      end else if (pend_q == PEND_TWO) begin
        pend_d = PEND_ONE;
        lead_d = in_byte_i;
      end else begin
        pend_d = PEND_NONE;
        buf_b  = put_byte(buf_b, n, {hex_val(lead_q), hex_val(in_byte_i)});
        n      = n + 2'd1;
      end
    end else if (is_crlf) begin
      line_d = 1'b1;
      buf_b  = put_byte(buf_b, n, in_byte_i);
      n      = n + 2'd1;
    end else if (in_byte_i == CH_EQ) begin
      line_d = 1'b0;
      pend_d = PEND_TWO;
    end else begin
      if (line_q && dot_stuffing_i && in_byte_i == CH_DOT) begin
        line_d = 1'b0;
      end else begin
        line_d = 1'b0;
        buf_b  = put_byte(buf_b, n, in_byte_i);
        n      = n + 2'd1;
      end
    end

    if (msg_last_i) begin
      // an escape still open here has emitted nothing yet
      if (pend_d != PEND_NONE) begin
        buf_b = put_byte(buf_b, n, CH_EQ);
        n     = n + 2'd1;
        if (pend_d == PEND_ONE) begin
          buf_b = put_byte(buf_b, n, lead_d);
          n     = n + 2'd1;
        end
      end
      pend_d = PEND_NONE;
      lead_d = 8'h00;
      line_d = 1'b1;
    end
  end

  assign q_push_o           = accept && (n != 2'd0);
  assign q_entry_o.bytes    = buf_b;
  assign q_entry_o.last_idx = n - 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      lead_q <= 8'h00;
      line_q <= 1'b1;
    end else if (accept) begin
      pend_q <= pend_d;
      lead_q <= lead_d;
      line_q <= line_d;
    end
  end

endmodule

// ===== rtl/qpd_queue.sv =====
module qpd_queue
  import qpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  qpd_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output qpd_entry_t head_o
);

  qpd_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]       wr_q, wr_d;
  logic [QPtrW-1:0]       rd_q, rd_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/qpd_back.sv =====
module qpd_back
  import qpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  qpd_entry_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       take;

  assign out_valid_o = !empty_i;
  assign out_byte_o  = head_i.bytes[idx_q];
  assign run_last_o  = (idx_q == head_i.last_idx);
  assign take        = out_valid_o && out_ready_i;
  assign pop_o       = take && run_last_o;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = run_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== rtl/quoted_printable_decoder_core.sv =====
// Quoted-printable decoder: one encoded byte accepted per cycle while the queue is not full.
// Decoded bytes of an accepted request are registered in the queue and offered from its head.
// The output gives one byte per cycle while out_ready_i is high, so a request that yields three
// bytes holds the output while they drain (two-entry queue absorbs bursts).
// Reset (rst_ni low, asynchronous): no pending escape, start of line, dot stuffing off,
// queue empty.
module quoted_printable_decoder_core
  import qpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              msg_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic       dot_q;
  logic       q_full, q_empty, q_push, q_pop;
  qpd_entry_t q_entry, q_head;
  logic       reg_hit;

  // one register, selected when paddr[2] is low
  assign reg_hit = (paddr[PaddrW-1] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(PdataW-1){1'b0}}, dot_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      dot_q <= pwdata[0];
    end
  end

  qpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dot_stuffing_i (dot_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .msg_last_i     (msg_last_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_entry)
  );

  qpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  qpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== test/qpd_checker.sv =====
module qpd_checker
  import qpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_byte_i,
  input  logic              msg_last_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        out_byte_i,
  input  logic              run_last_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic [PdataW-1:0] prdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                expected_left_o,
  output int                requests_o,
  output int                results_o
);

  localparam logic [PaddrW-1:0] ADDR_DOT_STUFFING = '0;
  localparam int              MAX_PRINTED       = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       tail;
  } decoded_t;

  decoded_t   decoded_q[$];
  logic       dot_stuffing;
  logic [1:0] pending;
  logic [7:0] lead;
  logic       at_line_start;

  // {is a hex digit, its value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count_o < MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic last);
    logic [7:0] bytes [3];
    logic [4:0] h;
    logic [4:0] lh;
    int         n;
    n = 0;
    h = hex_digit(c);
    lh = hex_digit(lead);
    if (pending != PEND_NONE) begin
      if (pending == PEND_TWO && (c == CH_CR || c == CH_LF)) begin
        // soft break: CR leaves the escape open, LF closes it
        at_line_start = 1'b1;
        if (c == CH_LF) pending = PEND_NONE;
      end else if (!h[4]) begin
        if (c == CH_CR || c == CH_LF) begin
          at_line_start = 1'b1;  // lead digit is lost
        end else begin
          bytes[n] = CH_EQ;
          n++;
          if (pending == PEND_ONE) begin
            bytes[n] = lead;
            n++;
          end
          bytes[n] = c;
          n++;
        end
        pending = PEND_NONE;
      end else if (pending == PEND_TWO) begin
        pending = PEND_ONE;
        lead = c;
      end else begin
        pending = PEND_NONE;
        bytes[n] = {lh[3:0], h[3:0]};
        n++;
      end
    end else if (c == CH_CR || c == CH_LF) begin
      at_line_start = 1'b1;
      bytes[n] = c;
      n++;
    end else if (c == CH_EQ) begin
      at_line_start = 1'b0;
      pending = PEND_TWO;
    end else begin
      if (!(at_line_start && dot_stuffing && c == CH_DOT)) begin
        bytes[n] = c;
        n++;
      end
      at_line_start = 1'b0;
    end

    if (last) begin
      // open escape goes out raw, capped at three bytes per request
      if (pending != PEND_NONE && n < 3) begin
        bytes[n] = CH_EQ;
        n++;
        if (pending == PEND_ONE && n < 3) begin
          bytes[n] = lead;
          n++;
        end
      end
      pending = PEND_NONE;
      lead = '0;
      at_line_start = 1'b1;
    end

    for (int k = 0; k < n; k++) decoded_q.push_back({bytes[k], k == n - 1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    decoded_t want;
    if (!rst_ni) begin
      dot_stuffing = 1'b0;
      pending = PEND_NONE;
      lead = '0;
      at_line_start = 1'b1;
      decoded_q.delete();
      expected_left_o <= 0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_DOT_STUFFING) begin
        if (pwrite) begin
          dot_stuffing = pwdata[0];
        end else if (prdata[0] !== dot_stuffing) begin
          report_mismatch($sformatf("dot_stuffing read %b, written %b", prdata[0], dot_stuffing));
        end
      end

      if (in_valid_i && in_ready_i) begin
        requests_o++;
        decode_byte(in_byte_i, msg_last_i);
      end

      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("byte %h arrived with nothing expected", out_byte_i));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data) begin
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte_i, want.data));
          end
          if (run_last_i !== want.tail) begin
            report_mismatch($sformatf("run_last %b, expected %b (byte %h)",
                                      run_last_i, want.tail, want.data));
          end
        end
      end

      expected_left_o <= decoded_q.size();
    end
  end

endmodule

// ===== test/quoted_printable_decoder_core_tb.sv =====
module quoted_printable_decoder_core_tb;
  import qpd_pkg::*;

  localparam int                IDLE_LIMIT        = 2000;
  localparam int                HOLD_CYCLES       = 64;
  localparam int                PHASE_BYTES       = 80;
  localparam logic [PaddrW-1:0] ADDR_DOT_STUFFING = '0;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [7:0]        in_byte_i   = '0;
  logic              msg_last_i  = 1'b0;
  logic              out_ready_i = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = ADDR_DOT_STUFFING;
  logic [PdataW-1:0] pwdata      = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [7:0]        out_byte_o;
  logic              run_last_o;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int   gap_pct     = 0;
  int   stall_pct   = 0;
  logic hold_req    = 1'b0;
  int   bytes_sent  = 0;
  int   idle_cycles = 0;
  int   fails;
  int   expected_left;
  int   requests;
  int   results;

  quoted_printable_decoder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .msg_last_i (msg_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  qpd_checker decode_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .msg_last_i     (msg_last_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_i     (out_byte_o),
    .run_last_i     (run_last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count_o   (fails),
    .expected_left_o(expected_left),
    .requests_o     (requests),
    .results_o      (results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("no progress for %0d cycles", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'h30 + 8'(v);
    if (v < 16) return 8'h41 + 8'(v - 10);
    return 8'h61 + 8'(v - 16);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    case ($urandom_range(0, 3))
      0:       return 8'h67 + 8'($urandom_range(0, 19));  // g..z
      1:       return 8'h47 + 8'($urandom_range(0, 19));  // G..Z
      2:       return 8'h20 + 8'($urandom_range(0, 15));  // punctuation, '.' too
      default: return 8'h80 + 8'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    msg_last_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // one message built from tokens: plain text, line breaks, escapes good and bad
  task automatic send_message();
    logic [7:0] msg[$];
    int         tokens;
    int         kind;
    int         k;
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1: msg.push_back(8'h20 + 8'($urandom_range(0, 94)));
        2:    msg.push_back(8'($urandom));
        3, 7: begin
          if (kind == 7) msg.push_back(CH_EQ);
          k = $urandom_range(0, 2);
          if (k != 1) msg.push_back(CH_CR);
          if (k != 2) msg.push_back(CH_LF);
        end
        4: begin
          msg.push_back(CH_LF);
          msg.push_back(CH_DOT);
        end
        5, 6: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_hex());
          msg.push_back(pick_hex());
        end
        8: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_non_hex());
        end
        9: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_hex());
          msg.push_back(pick_non_hex());
        end
        10: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_hex());
          msg.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
        default: begin
          // escape left open; flushed if it ends the message
          msg.push_back(CH_EQ);
          if ($urandom_range(0, 1)) msg.push_back(pick_hex());
        end
      endcase
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // setup and access, no deassert: back-to-back transfers keep psel high
  task automatic apb_transfer(input logic write, input logic [PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_dot_stuffing(input logic on);
    apb_transfer(1'b1, PdataW'(on));
    apb_transfer(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_for_drain();
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    string directed;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dot stuffing on: dots at line start, escapes of both cases, soft breaks,
    // hex after a soft CR, lost lead digit, broken escape, flush at message end
    set_dot_stuffing(1'b1);
    directed = {".a.\015.\012", "=fF", "=\0154a", "=\012.", "=7\012", "=3z", "=5"};
    for (int i = 0; i < directed.len(); i++) begin
      send_byte(directed[i], i == directed.len() - 1);
    end
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    in_valid_i <= 1'b0;
    wait_for_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 49; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      set_dot_stuffing(phase[0]);
      if (phase == 0) hold_req = 1'b1;
      k_target: begin
        int target;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) send_message();
      end
      in_valid_i <= 1'b0;
      wait_for_drain();
    end

    $display("%0d requests in, %0d decoded bytes out, four idling patterns", requests, results);
    $display("dot stuffing on and off, one long output hold-off with input pressing");
    if (fails == 0 && expected_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
